>>> rtl/core/vban_pcm16_packetizer_core_defines.svh
// assertion macros for the vban pcm16 packetizer core
`ifndef VBAN_PCM16_PACKETIZER_CORE_DEFINES_SVH
`define VBAN_PCM16_PACKETIZER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define VPK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vpk check failed");

// next-cycle implication, disabled while reset is high
`define VPK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vpk check failed");

`endif

>>> rtl/core/vpk_pkg.sv
// package with constants and helpers for the vban pcm16 packetizer
package vpk_pkg;

   localparam int unsigned MaxPacketFrames = 256;
   localparam int unsigned MaxChannels     = 8;
   localparam int unsigned FloatCapSamples = 8192;

   // byte positions inside one item's output run
   localparam logic [4:0] HdrFirstIdx     = 5'd0;
   localparam logic [4:0] NameFirstIdx    = 5'd8;
   localparam logic [4:0] CounterFirstIdx = 5'd24;
   localparam logic [4:0] PayloadLoIdx    = 5'd28;
   localparam logic [4:0] LastIdx         = 5'd29;

   localparam logic [7:0] FmtInt16 = 8'h01;

   // register indexes of the csr port
   localparam logic [2:0] CsrRateIndex  = 3'd0;
   localparam logic [2:0] CsrChannelsM1 = 3'd1;
   localparam logic [2:0] CsrIsFloat    = 3'd2;
   localparam logic [2:0] CsrNameLow    = 3'd3;
   localparam logic [2:0] CsrNameHigh   = 3'd4;

   // one item waiting to be serialized
   typedef struct packed {
      logic        has_header;
      logic [7:0]  frames_m1;
      logic [31:0] counter;
      logic [15:0] pcm;
      logic        pkt_end;
   } job_type;

   // fixed magic bytes of the header
   function automatic logic [7:0] magic_byte(input logic [1:0] pos);
      logic [7:0] b;
      unique case (pos)
         2'd0: b = 8'h56;
         2'd1: b = 8'h42;
         2'd2: b = 8'h41;
         2'd3: b = 8'h4E;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // frame cap of one buffer per channel count
   function automatic logic [15:0] buffer_cap(input logic [2:0] chans_m1);
      logic [15:0] c;
      unique case (chans_m1)
         3'd0: c = 16'(FloatCapSamples / 1);
         3'd1: c = 16'(FloatCapSamples / 2);
         3'd2: c = 16'(FloatCapSamples / 3);
         3'd3: c = 16'(FloatCapSamples / 4);
         3'd4: c = 16'(FloatCapSamples / 5);
         3'd5: c = 16'(FloatCapSamples / 6);
         3'd6: c = 16'(FloatCapSamples / 7);
         3'd7: c = 16'(FloatCapSamples / 8);
         default: c = 16'(FloatCapSamples / 8);
      endcase
      return c;
   endfunction

endpackage

>>> rtl/core/vban_pcm16_packetizer_core.sv
// top level of the vban pcm16 packetizer: sample in, vban byte stream out
//
//  channel | group | payload (lowest bit first)
//  --------+-------+-----------------------------------------------------
//  input   | req_  | tuser: buffer_start; tdata: buffer_frames, sample_bits
//  output  | rsp_  | tdata: out_byte; tuser: is_header, packet_end; tlast: run_end
//  config  | csr_  | we, index 0..4, wdata up to 64 bits
//
// an item is decoded in the cycle it is accepted: buffer and packet state, the
// header fields and the int16 sample are registered into a job register
// the job is then sent one byte per cycle while rsp_tready is high: 2 bytes for a plain
// sample, 30 bytes when a 28-byte header goes first; a dropped sample is taken with no byte
// the next item is taken in the same cycle the last byte of a job leaves,
// so a stall on rsp_ holds the job and stalls req_ only
// reset is synchronous and clears config to its defaults and all stream state
`include "vban_pcm16_packetizer_core_defines.svh"

module vban_pcm16_packetizer_core
   import vpk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // buffer_frames[15:0], sample_bits[47:16]
   input  logic        req_tuser,   // buffer_start

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic [1:0]  rsp_tuser,   // is_header[0], packet_end[1]
   output logic        rsp_tlast,   // run_end

   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // configuration registers
   logic [4:0]  rate_ff;
   logic [2:0]  chans_m1_ff;
   logic        float_mode_ff;
   logic [63:0] name_low_ff;
   logic [63:0] name_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff       <= 5'd3;
         chans_m1_ff   <= 3'd1;
         float_mode_ff <= 1'b1;
         name_low_ff   <= '0;
         name_high_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrRateIndex:  rate_ff       <= csr_wdata[4:0];
            CsrChannelsM1: chans_m1_ff   <= csr_wdata[2:0];
            CsrIsFloat:    float_mode_ff <= csr_wdata[0];
            CsrNameLow:    name_low_ff   <= csr_wdata;
            CsrNameHigh:   name_high_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stream state
   logic [31:0] counter_ff, counter_in;
   logic [15:0] buf_left_ff, buf_left_in;
   logic [8:0]  pkt_left_ff, pkt_left_in;
   logic [2:0]  chan_pos_ff, chan_pos_in;

   // job register and byte index of the serializer
   job_type     job_ff, job_in;
   logic        job_valid_ff, job_valid_in;
   logic [4:0]  idx_ff, idx_in;

   logic        accept;
   logic        last_taken;
   logic        emit;

   assign last_taken = job_valid_ff && rsp_tready && (idx_ff == LastIdx);
   assign req_tready = !job_valid_ff || last_taken;
   assign accept     = req_tvalid && req_tready;

   // item fields
   logic        in_start;
   logic [15:0] in_frames;
   logic [31:0] in_bits;

   assign in_start  = req_tuser;
   assign in_frames = req_tdata[15:0];
   assign in_bits   = req_tdata[47:16];

   // float32 to int16: clamp to +-1, exact multiply by 32767, truncate
   logic        f_neg;
   logic [7:0]  f_exp;
   logic [22:0] f_man;
   logic [23:0] f_sig;
   logic [38:0] f_prod;
   logic [7:0]  f_shift;
   logic [38:0] f_shifted;
   logic [14:0] f_mag;
   logic [15:0] f_pcm;
   logic [15:0] pcm;

   always_comb begin
      f_neg     = in_bits[31];
      f_exp     = in_bits[30:23];
      f_man     = in_bits[22:0];
      f_sig     = (f_exp == 8'd0) ? {1'b0, f_man} : {1'b1, f_man};
      f_prod    = 39'(f_sig) * 39'd32767;
      f_shift   = (f_exp == 8'd0) ? 8'd149 : (8'd150 - f_exp);
      f_shifted = f_prod >> f_shift[5:0];
      if (f_exp == 8'hFF && f_man != 23'd0) begin
         f_mag = 15'd0;                    // nan
      end else if (f_exp >= 8'd127) begin
         f_mag = 15'd32767;                // clamp, infinities included
      end else if (f_shift >= 8'd39) begin
         f_mag = 15'd0;
      end else begin
         f_mag = f_shifted[14:0];
      end
      f_pcm = f_neg ? (16'd0 - {1'b0, f_mag}) : {1'b0, f_mag};
      pcm   = float_mode_ff ? f_pcm : in_bits[15:0];
   end

   // buffer, packet and channel bookkeeping for one accepted item
   logic [15:0] cap;
   logic [15:0] bl_start;
   logic [8:0]  pl_start;
   logic [2:0]  cp_start;
   logic [8:0]  pkt_frames;
   logic [8:0]  pl_hdr;
   logic [15:0] bl_hdr;
   logic [2:0]  cp_hdr;
   logic        need_hdr;
   logic        frame_done;

   always_comb begin
      cap      = buffer_cap(chans_m1_ff);
      bl_start = buf_left_ff;
      pl_start = pkt_left_ff;
      cp_start = chan_pos_ff;
      if (in_start) begin
         bl_start = (in_frames > cap) ? cap : in_frames;
         pl_start = 9'd0;
         cp_start = 3'd0;
      end

      need_hdr   = (pl_start == 9'd0);
      pkt_frames = (bl_start > 16'(MaxPacketFrames)) ? 9'(MaxPacketFrames)
                                                     : bl_start[8:0];
      emit       = !need_hdr || (bl_start != 16'd0);

      pl_hdr = pl_start;
      bl_hdr = bl_start;
      cp_hdr = cp_start;
      if (need_hdr) begin
         pl_hdr = pkt_frames;
         bl_hdr = bl_start - 16'(pkt_frames);
         cp_hdr = 3'd0;
      end

      frame_done = ({1'b0, cp_hdr} + 4'd1) >= ({1'b0, chans_m1_ff} + 4'd1);

      counter_in  = counter_ff;
      buf_left_in = buf_left_ff;
      pkt_left_in = pkt_left_ff;
      chan_pos_in = chan_pos_ff;
      job_in      = job_ff;

      if (accept) begin
         // a dropped sample still applies a buffer restart
         buf_left_in = bl_start;
         pkt_left_in = pl_start;
         chan_pos_in = cp_start;
         if (emit) begin
            buf_left_in = bl_hdr;
            if (frame_done) begin
               chan_pos_in = 3'd0;
               pkt_left_in = pl_hdr - 9'd1;
            end else begin
               chan_pos_in = cp_hdr + 3'd1;
               pkt_left_in = pl_hdr;
            end
            if (need_hdr) begin
               counter_in = counter_ff + 32'd1;
            end
            job_in.has_header = need_hdr;
            job_in.frames_m1  = 8'(pkt_frames - 9'd1);
            job_in.counter    = counter_ff;
            job_in.pcm        = pcm;
            job_in.pkt_end    = frame_done && (pl_hdr == 9'd1);
         end
      end
   end

   // serializer control
   always_comb begin
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      if (job_valid_ff && rsp_tready) begin
         idx_in = idx_ff + 5'd1;
         if (idx_ff == LastIdx) begin
            job_valid_in = 1'b0;
         end
      end
      if (accept && emit) begin
         job_valid_in = 1'b1;
         idx_in       = job_in.has_header ? HdrFirstIdx : PayloadLoIdx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         buf_left_ff  <= '0;
         pkt_left_ff  <= '0;
         chan_pos_ff  <= '0;
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         counter_ff   <= counter_in;
         buf_left_ff  <= buf_left_in;
         pkt_left_ff  <= pkt_left_in;
         chan_pos_ff  <= chan_pos_in;
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   // name bytes, zeroed from the first zero byte on
   logic [127:0] name_all;
   logic [15:0]  name_alive;
   logic [3:0]   name_pos;
   logic [7:0]   name_byte;

   always_comb begin
      name_all = {name_high_ff, name_low_ff};
      for (int i = 0; i < 16; i++) begin
         if (i == 0) begin
            name_alive[i] = (name_all[7:0] != 8'd0);
         end else begin
            name_alive[i] = name_alive[i-1] && (name_all[i*8 +: 8] != 8'd0);
         end
      end
      name_pos  = 4'(idx_ff - NameFirstIdx);
      name_byte = name_alive[name_pos] ? name_all[name_pos*8 +: 8] : 8'd0;
   end

   // output byte select
   logic [1:0] cnt_pos;
   logic       hdr_byte;

   always_comb begin
      cnt_pos  = 2'(idx_ff - CounterFirstIdx);
      hdr_byte = (idx_ff < PayloadLoIdx);
      priority if (idx_ff < 5'd4) begin
         rsp_tdata = magic_byte(idx_ff[1:0]);
      end else if (idx_ff == 5'd4) begin
         rsp_tdata = {3'd0, rate_ff};
      end else if (idx_ff == 5'd5) begin
         rsp_tdata = job_ff.frames_m1;
      end else if (idx_ff == 5'd6) begin
         rsp_tdata = {5'd0, chans_m1_ff};
      end else if (idx_ff == 5'd7) begin
         rsp_tdata = FmtInt16;
      end else if (idx_ff < CounterFirstIdx) begin
         rsp_tdata = name_byte;
      end else if (idx_ff < PayloadLoIdx) begin
         rsp_tdata = job_ff.counter[cnt_pos*8 +: 8];
      end else if (idx_ff == PayloadLoIdx) begin
         rsp_tdata = job_ff.pcm[7:0];
      end else begin
         rsp_tdata = job_ff.pcm[15:8];
      end
   end

   assign rsp_tvalid   = job_valid_ff;
   assign rsp_tlast    = (idx_ff == LastIdx);
   assign rsp_tuser[0] = hdr_byte;
   assign rsp_tuser[1] = (idx_ff == LastIdx) && job_ff.pkt_end;

   // checks
   `VPK_ASSERT_NOW(a_take_only_at_end, clock, reset,
      accept && job_valid_ff, (idx_ff == LastIdx) && rsp_tready)
   `VPK_ASSERT_NOW(a_last_is_payload, clock, reset,
      rsp_tvalid && rsp_tlast, !rsp_tuser[0])
   `VPK_ASSERT_NOW(a_pkt_left_bound, clock, reset,
      1'b1, pkt_left_ff <= 9'(MaxPacketFrames))
   `VPK_ASSERT_NEXT(a_hdr_starts_run, clock, reset,
      accept && emit && need_hdr, job_valid_ff && (idx_ff == HdrFirstIdx))

endmodule
